FILE: hw/rtl/bjs_pkg.sv
package bjs_pkg;

  localparam int unsigned VALUE_BITS = 64;

  localparam logic signed [1:0] SYM_ZERO = 2'sb00;
  localparam logic signed [1:0] SYM_POS  = 2'sb01;
  localparam logic signed [1:0] SYM_NEG  = 2'sb11;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic publish;
  } bjs_cmd_t;

  typedef struct packed {
    logic finish;
  } bjs_sts_t;

endpackage

FILE: hw/rtl/bjs_in_if.sv
interface bjs_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

FILE: hw/rtl/bjs_out_if.sv
interface bjs_out_if;
  logic              valid;
  logic              ready;
  logic signed [1:0] symbol;
  logic              bad_operand;

  modport source (output valid, output symbol, output bad_operand, input ready);
  modport sink (input valid, input symbol, input bad_operand, output ready);
endinterface

FILE: hw/rtl/bjs_ctrl.sv
module bjs_ctrl import bjs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  bjs_sts_t sts,
  output bjs_cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts.finish && out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.load    = 1'b0;
    cmd.step    = 1'b0;
    cmd.publish = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_RUN: begin
        cmd.step    = !sts.finish;
        cmd.publish = sts.finish && out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!out_valid || out_ready))
    else $error("result published over a waiting word");

  a_load_runs: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_RUN))
    else $error("load did not start a run");

  a_run_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) && !sts.finish |=> (state == ST_RUN))
    else $error("run left before finish");

  a_step_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.step && (cmd.publish || cmd.load)))
    else $error("step overlaps load or publish");

endmodule

FILE: hw/rtl/bjs_dp.sv
module bjs_dp import bjs_pkg::*; #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [VALUE_BITS-1:0] cfg_wdata,
  input  logic [VALUE_BITS-1:0] value,
  input  bjs_cmd_t              cmd,
  output bjs_sts_t              sts,
  output logic signed [1:0]     symbol,
  output logic                  bad_operand
);

  logic [WORD_BITS-1:0] modulus;
  logic [WORD_BITS-1:0] a;
  logic [WORD_BITS-1:0] n;
  logic                 s;
  logic                 bad;

  logic [WORD_BITS-1:0] x_in;
  logic [WORD_BITS:0]   a_sub_n;
  logic [WORD_BITS-1:0] n_sub_a;
  logic                 a_lt_n;
  logic                 n_two_flip;
  logic                 a_two_flip;
  logic                 recip_flip;
  logic [WORD_BITS-1:0] a_next;
  logic [WORD_BITS-1:0] n_next;
  logic                 s_next;

  assign x_in       = value[WORD_BITS-1:0];
  assign a_sub_n    = {1'b0, a} - {1'b0, n};
  assign n_sub_a    = n - a;
  assign a_lt_n     = a_sub_n[WORD_BITS];
  assign n_two_flip = n[1] ^ n[2];
  assign a_two_flip = a[1] ^ a[2];
  assign recip_flip = a[1] & n[1];

  always_comb begin
    a_next = a;
    n_next = n;
    s_next = s;
    if (!a[0]) begin
      a_next = a >> 1;
      s_next = s ^ n_two_flip;
    end else if (!a_lt_n) begin
      a_next = a_sub_n[WORD_BITS:1];
      s_next = s ^ n_two_flip;
    end else begin
      a_next = n_sub_a >> 1;
      n_next = a;
      s_next = s ^ recip_flip ^ a_two_flip;
    end
  end

  assign sts.finish = bad || (a == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= {{(WORD_BITS-1){1'b0}}, 1'b1};
    end else if (cfg_we) begin
      modulus <= cfg_wdata[WORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a   <= x_in;
      n   <= modulus;
      s   <= 1'b0;
      bad <= !modulus[0] || (x_in >= modulus);
    end else if (cmd.step) begin
      a <= a_next;
      n <= n_next;
      s <= s_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      bad_operand <= bad;
      if (bad || (n != {{(WORD_BITS-1){1'b0}}, 1'b1})) begin
        symbol <= SYM_ZERO;
      end else begin
        symbol <= s ? SYM_NEG : SYM_POS;
      end
    end
  end

endmodule

FILE: hw/rtl/binary_jacobi_symbol.sv
// Binary Jacobi symbol unit: each input word carries x, and one output word
// returns (x / m) as -1, 0 or +1 against the odd modulus m held in the config
// register (reset value 1; the user is to write it through cfg_we/cfg_wdata
// only while idle, which the block itself does not enforce), with
// bad_operand set and symbol 0 when m is even or x >= m. Operands are cut
// to the low WORD_BITS bits. One word is worked at a time: after acceptance,
// a shared subtract-and-halve step runs once per cycle and at least halves
// the product of the two operands until the run finishes. The result
// sits in an output register, so a new word is taken while the previous
// result waits to be read.
module binary_jacobi_symbol import bjs_pkg::*; #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [VALUE_BITS-1:0] cfg_wdata,
  bjs_in_if.sink                in_ch,
  bjs_out_if.source             out_ch
);

  bjs_cmd_t cmd;
  bjs_sts_t sts;

  bjs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bjs_dp #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .value       (in_ch.value),
    .cmd         (cmd),
    .sts         (sts),
    .symbol      (out_ch.symbol),
    .bad_operand (out_ch.bad_operand)
  );

endmodule

FILE: dv/testbench.sv
module testbench import bjs_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WORD_BITS = 64;
  localparam logic [63:0] WORD_MASK = {64{1'b1}} >> (64 - WORD_BITS);
  localparam logic [63:0] ALL_ONES = {64{1'b1}};
  localparam logic [63:0] TOP_PRIME = 64'hFFFF_FFFF_FFFF_FFC5;
  localparam int RANDOM_PHASES = 16;
  localparam int WORDS_PER_PHASE = 96;
  localparam int HOLD_CYCLES = 1000;
  localparam int HOLD_AFTER_WORDS = 150;
  localparam int QUIET_LIMIT = 8000;
  localparam int SETTLE_CYCLES = 200;
  localparam int PRINT_CAP = 40;

  typedef struct {
    logic [63:0]       x;
    logic [63:0]       m;
    logic signed [1:0] symbol;
    logic              bad;
  } symbol_due_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [VALUE_BITS-1:0] cfg_wdata;

  bjs_in_if  value_ch ();
  bjs_out_if symbol_ch ();

  binary_jacobi_symbol #(
    .WORD_BITS(WORD_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (value_ch),
    .out_ch   (symbol_ch)
  );

  logic [63:0]  pending_values[$];
  symbol_due_t  owed_symbols[$];
  symbol_due_t  due;
  logic [63:0]  modulus_now;
  bit           idle_on;
  bit           hold_rx;
  int           send_gap;
  int           recv_gap;
  int           quiet;
  int           words_in;
  int           mismatches;
  int           settings;
  int           n_bad;
  int           n_pos;
  int           n_neg;
  int           n_zero;

  function automatic int unsigned low_zeros(logic [63:0] v);
    int unsigned n;
    n = 0;
    while (n < 63 && !v[n]) n++;
    return n;
  endfunction

  function automatic symbol_due_t predict_symbol(logic [63:0] x_in, logic [63:0] m_in);
    symbol_due_t r;
    logic [63:0] x;
    logic [63:0] m;
    logic [63:0] s;
    int unsigned j;
    x = x_in & WORD_MASK;
    m = m_in & WORD_MASK;
    r.x = x_in;
    r.m = m_in;
    r.symbol = SYM_ZERO;
    r.bad = 1'b0;
    if (!m[0] || x >= m) begin
      r.bad = 1'b1;
      return r;
    end
    if (x == 0) begin
      if (m == 1) r.symbol = SYM_POS;
      return r;
    end
    j = low_zeros(x);
    x = x >> j;
    s = (64'(j) << 1) & (m ^ (m >> 1));
    while (x > 1) begin
      s ^= x & m;
      do begin
        m -= x;
        if (m == 0) break;
        j = low_zeros(m);
        s ^= (64'(j) << 1) & (x ^ (x >> 1));
        m = m >> j;
      end while (m >= x);
      if (m <= 1) begin
        x = m;
        break;
      end
      s ^= x & m;
      do begin
        x -= m;
        if (x == 0) break;
        j = low_zeros(x);
        s ^= (64'(j) << 1) & (m ^ (m >> 1));
        x = x >> j;
      end while (x >= m);
    end
    if (x != 0) r.symbol = s[1] ? SYM_NEG : SYM_POS;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int pick_gap(bit enable);
    int r;
    if (!enable) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 400);
  endfunction

  function automatic logic [63:0] pick_modulus(int phase);
    logic [63:0] a;
    logic [63:0] b;
    int w;
    case (phase)
      0: return ALL_ONES;
      1: return TOP_PRIME;
      2: return 64'd1;
      3: return rand64() & ~64'd1;
      default: begin
        case ($urandom_range(5))
          0: return rand64() | 64'd1;
          1: begin
            w = $urandom_range(2, 64);
            return (rand64() >> (64 - w)) | 64'd1;
          end
          2: begin
            a = 2 * $urandom_range(1, 500) + 1;
            b = 2 * $urandom_range(1, 500) + 1;
            return a * b;
          end
          3: return rand64() & ~64'd1;
          4: return {1'b1, 62'd0, 1'b1};
          default: return (rand64() >> $urandom_range(40, 62)) | 64'd1;
        endcase
      end
    endcase
  endfunction

  function automatic logic [63:0] pick_value(logic [63:0] m);
    logic [63:0] v;
    int k;
    v = (m == 0) ? rand64() : rand64() % m;
    case ($urandom_range(19))
      0: return 64'd0;
      1: return m - 1;
      2: return m;
      3: return rand64();
      4: return 64'd1;
      5, 6: begin
        k = $urandom_range(0, 63);
        return v & ~((64'd1 << k) - 1);
      end
      default: return v;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < PRINT_CAP) $display("%0t ns mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic queue_value(logic [63:0] v);
    pending_values.push_back(v);
  endtask

  task automatic drain();
    @(negedge clk);
    while (pending_values.size() != 0 || value_ch.valid || owed_symbols.size() != 0)
      @(negedge clk);
  endtask

  task automatic load_modulus(logic [63:0] m, bit idle);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    idle_on <= idle;
    @(posedge clk);
    cfg_we <= 1'b0;
    modulus_now = m;
    settings++;
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    hold_rx = 1'b0;
    wait (words_in >= HOLD_AFTER_WORDS);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      value_ch.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (value_ch.valid && value_ch.ready) begin
        owed_symbols.push_back(predict_symbol(value_ch.value, modulus_now));
        words_in <= words_in + 1;
      end
      if (!value_ch.valid || value_ch.ready) begin
        if (send_gap != 0) begin
          value_ch.valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_values.size() != 0) begin
          value_ch.valid <= 1'b1;
          value_ch.value <= pending_values.pop_front();
          send_gap <= pick_gap(idle_on);
        end else begin
          value_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      symbol_ch.ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (symbol_ch.valid && symbol_ch.ready) begin
        if (owed_symbols.size() == 0) begin
          report_mismatch($sformatf("symbol %0d bad %0b with nothing owed",
                                    symbol_ch.symbol, symbol_ch.bad_operand));
        end else begin
          due = owed_symbols.pop_front();
          if (symbol_ch.symbol !== due.symbol)
            report_mismatch($sformatf("x=%h m=%h symbol %0d, want %0d",
                                      due.x, due.m, symbol_ch.symbol, due.symbol));
          if (symbol_ch.bad_operand !== due.bad)
            report_mismatch($sformatf("x=%h m=%h bad_operand %0b, want %0b",
                                      due.x, due.m, symbol_ch.bad_operand, due.bad));
          if (due.bad) n_bad++;
          else if (due.symbol == SYM_POS) n_pos++;
          else if (due.symbol == SYM_NEG) n_neg++;
          else n_zero++;
        end
      end
      if (hold_rx) begin
        symbol_ch.ready <= 1'b0;
      end else if (recv_gap != 0) begin
        symbol_ch.ready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else begin
        symbol_ch.ready <= 1'b1;
        if (symbol_ch.valid && symbol_ch.ready) recv_gap <= pick_gap(idle_on);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (value_ch.valid && value_ch.ready) || (symbol_ch.valid && symbol_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: %0d cycles with no word moving", quiet);
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    logic [63:0] m;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    value_ch.valid = 1'b0;
    value_ch.value = '0;
    symbol_ch.ready = 1'b0;
    idle_on = 1'b0;
    modulus_now = 64'd1;
    words_in = 0;
    mismatches = 0;
    settings = 0;
    n_bad = 0;
    n_pos = 0;
    n_neg = 0;
    n_zero = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    queue_value(64'd0);
    queue_value(64'd1);
    queue_value(ALL_ONES);
    drain();

    load_modulus(64'd0, 1'b0);
    queue_value(64'd0);
    queue_value(64'd5);
    drain();

    load_modulus(64'd2, 1'b0);
    queue_value(64'd1);
    drain();

    load_modulus(ALL_ONES, 1'b0);
    queue_value(64'd0);
    queue_value(64'd1);
    queue_value(64'd2);
    queue_value(64'd3);
    queue_value(64'h8000_0000_0000_0000);
    queue_value(ALL_ONES - 1);
    queue_value(ALL_ONES);
    queue_value(64'h5555_5555_5555_5555);
    drain();

    load_modulus(TOP_PRIME, 1'b0);
    queue_value(64'd2);
    queue_value(64'd3);
    queue_value(TOP_PRIME - 1);
    queue_value(TOP_PRIME + 1);
    drain();

    load_modulus(64'd9, 1'b0);
    queue_value(64'd3);
    queue_value(64'd2);
    queue_value(64'd8);
    queue_value(64'd10);
    drain();

    load_modulus(64'h8000_0000_0000_0000, 1'b0);
    queue_value(64'd0);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      m = pick_modulus(ph);
      load_modulus(m, (ph % 3) != 0);
      for (int i = 0; i < WORDS_PER_PHASE; i++) queue_value(pick_value(m));
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    while (owed_symbols.size() != 0) begin
      due = owed_symbols.pop_front();
      report_mismatch($sformatf("no result for x=%h m=%h", due.x, due.m));
    end

    $display("%0d words over %0d modulus settings, receiver held off %0d cycles once",
             words_in, settings, HOLD_CYCLES);
    $display("results: %0d flagged, %0d of +1, %0d of -1, %0d of 0; %0d mismatches",
             n_bad, n_pos, n_neg, n_zero, mismatches);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
